// ===== rtl/core/packed_pixel_to_rgb888_assert.svh =====
// Assertion macros for the packed pixel unpacker.
// Included by every RTL file that carries concurrent assertions.
`ifndef PACKED_PIXEL_TO_RGB888_ASSERT_SVH
`define PACKED_PIXEL_TO_RGB888_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define PPR_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) !rst_n |=> prop) \
        else $error("%m: reset assertion failed");
`else
`define PPR_ASSERT(lbl, clk, rst_n, prop)
`define PPR_ASSERT_RST(lbl, clk, rst_n, prop)
`endif

`endif

// ===== rtl/core/ppr_pkg.sv =====
// Shared types, codes and field helpers for the packed pixel unpacker.
// No dependencies; used by all RTL files of the block.
package ppr_pkg;

    localparam int unsigned CHAN_BITS = 8;
    localparam int unsigned CFG_DATA_BITS = 4;
    localparam int unsigned CFG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_NONE  = 2'd3
    } t_chan;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BPP         = 3'd0,
        CFG_FIRST_BITS  = 3'd1,
        CFG_SECOND_BITS = 3'd2,
        CFG_THIRD_BITS  = 3'd3,
        CFG_FIRST_DEST  = 3'd4,
        CFG_SECOND_DEST = 3'd5,
        CFG_THIRD_DEST  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] bpp;
        logic [3:0] first_bits;
        logic [3:0] second_bits;
        logic [3:0] third_bits;
        logic [1:0] first_dest;
        logic [1:0] second_dest;
        logic [1:0] third_dest;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_BITS-1:0] b0;
        logic [CHAN_BITS-1:0] b1;
        logic [CHAN_BITS-1:0] b2;
        logic [1:0]           n;
    } t_pix;

    function automatic logic [3:0] sat_bits(input logic [3:0] w);
        return (w > 4'd8) ? 4'd8 : w;
    endfunction

    // low w bits of (word >> pos), moved to the top of the channel
    function automatic logic [CHAN_BITS-1:0] take_field(input logic [15:0] word,
                                                        input logic [4:0]  pos,
                                                        input logic [3:0]  w);
        logic [15:0] v;
        logic [3:0]  sh;
        v  = word >> pos;
        sh = 4'd8 - w;
        return v[CHAN_BITS-1:0] << sh;
    endfunction

endpackage

// ===== rtl/core/ppr_if.sv =====
// Stream interfaces of the packed pixel unpacker: source bytes in, RGB888 out.
// Depends on ppr_pkg for the channel width.
interface ppr_byte_if
    import ppr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

interface ppr_rgb_if
    import ppr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/ppr_collect.sv =====
// Byte collector: tracks the byte phase, holds partial pixels and registers
// each completed pixel for the unpack stage. Depends on ppr_pkg and ppr_if.
`include "packed_pixel_to_rgb888_assert.svh"

module ppr_collect
    import ppr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    ppr_byte_if.sink   i_byte,
    output logic       o_s_valid,
    input  logic       i_s_ready,
    output t_pix       o_pix
);

    logic [1:0]           r_phase;
    logic                 r_s_valid;
    t_pix                 r_pix;
    logic [CHAN_BITS-1:0] r_held [2];

    logic [1:0] ph;
    logic [1:0] n;
    logic [2:0] ph_next;
    logic       complete;
    logic       accept;
    t_pix       n_pix;

    always_comb begin
        ph       = (r_phase == 2'd3) ? 2'd2 : r_phase;
        n        = (i_cfg.bpp == 2'd0) ? 2'd1 : i_cfg.bpp;
        ph_next  = {1'b0, ph} + 3'd1;
        complete = (ph_next >= {1'b0, n});
        n_pix.n  = n;
        n_pix.b0 = (ph == 2'd0) ? i_byte.src_byte : r_held[0];
        n_pix.b1 = (ph == 2'd1) ? i_byte.src_byte : r_held[1];
        n_pix.b2 = (ph == 2'd2) ? i_byte.src_byte : '0;
    end

    assign i_byte.ready = !r_s_valid || i_s_ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign o_s_valid    = r_s_valid;
    assign o_pix        = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 2'd0;
            r_s_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= complete ? 2'd0 : ph_next[1:0];
            end
            if (accept && complete) begin
                r_s_valid <= 1'b1;
            end else if (i_s_ready) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !complete) begin
            r_held[ph[0]] <= i_byte.src_byte;
        end
        if (accept && complete) begin
            r_pix <= n_pix;
        end
    end

    `PPR_ASSERT(a_complete_loads, i_clk, i_rst_n, (accept && complete) |=> r_s_valid)
    `PPR_ASSERT(a_phase_advance, i_clk, i_rst_n,
                (accept && !complete) |=> (r_phase == $past(ph_next[1:0])))
    `PPR_ASSERT(a_stage_holds, i_clk, i_rst_n,
                (r_s_valid && !i_s_ready) |=> (r_s_valid && $stable(r_pix)))
    `PPR_ASSERT_RST(a_reset_phase, i_clk, i_rst_n, (r_phase == 2'd0) && !r_s_valid)

endmodule

// ===== rtl/core/ppr_unpack.sv =====
// Unpack stage: splits a collected pixel into fields, merges them into the
// held channel values and drives the result register. Depends on ppr_pkg, ppr_if.
`include "packed_pixel_to_rgb888_assert.svh"

module ppr_unpack
    import ppr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_s_valid,
    output logic      o_s_ready,
    input  t_pix      i_pix,
    ppr_rgb_if.source o_rgb
);

    logic                 r_o_valid;
    logic [CHAN_BITS-1:0] r_red;
    logic [CHAN_BITS-1:0] r_green;
    logic [CHAN_BITS-1:0] r_blue;
    logic [CHAN_BITS-1:0] n_red;
    logic [CHAN_BITS-1:0] n_green;
    logic [CHAN_BITS-1:0] n_blue;

    logic                 o_free;
    logic                 load;
    logic [3:0]           fb;
    logic [3:0]           sb;
    logic [3:0]           tb;
    logic [15:0]          word;
    logic [4:0]           pos1;
    logic [CHAN_BITS-1:0] f [3];
    logic [1:0]           dest [3];

    always_comb begin
        fb   = sat_bits(i_cfg.first_bits);
        sb   = sat_bits(i_cfg.second_bits);
        tb   = sat_bits(i_cfg.third_bits);
        word = (i_pix.n == 2'd2) ? {i_pix.b0, i_pix.b1} : {8'h00, i_pix.b0};
        pos1 = {1'b0, sb} + {1'b0, tb};
        if (i_pix.n == 2'd3) begin
            f[0] = i_pix.b0;
            f[1] = i_pix.b1;
            f[2] = i_pix.b2;
        end else begin
            f[0] = take_field(word, pos1, fb);
            f[1] = take_field(word, {1'b0, tb}, sb);
            f[2] = take_field(word, 5'd0, tb);
        end
    end

    assign dest[0] = i_cfg.first_dest;
    assign dest[1] = i_cfg.second_dest;
    assign dest[2] = i_cfg.third_dest;

    always_comb begin
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        for (int i = 0; i < 3; i++) begin
            case (t_chan'(dest[i]))
                CH_RED:   n_red   = f[i];
                CH_GREEN: n_green = f[i];
                CH_BLUE:  n_blue  = f[i];
                default:  ;
            endcase
        end
    end

    assign o_free      = !r_o_valid || o_rgb.ready;
    assign load        = i_s_valid && o_free;
    assign o_s_ready   = o_free;
    assign o_rgb.valid = r_o_valid;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
        end else begin
            if (o_free) begin
                r_o_valid <= i_s_valid;
            end
            if (load) begin
                r_red   <= n_red;
                r_green <= n_green;
                r_blue  <= n_blue;
            end
        end
    end

    `PPR_ASSERT(a_load_shows, i_clk, i_rst_n, load |=> r_o_valid)
    `PPR_ASSERT(a_idle_keeps, i_clk, i_rst_n,
                !load |=> ($stable(r_red) && $stable(r_green) && $stable(r_blue)))
    `PPR_ASSERT(a_no_load_stalled, i_clk, i_rst_n,
                (r_o_valid && !o_rgb.ready) |-> !load)

endmodule

// ===== rtl/core/packed_pixel_to_rgb888.sv =====
// Top level of the packed pixel to RGB888 unpacker: configuration registers,
// byte collector and unpack stage. Depends on ppr_pkg, ppr_if, ppr_collect, ppr_unpack.
//
//  port      dir   handshake       payload
//  i_byte    in    valid/ready     src_byte[7:0]
//  o_rgb     out   valid/ready     red[7:0] green[7:0] blue[7:0]
//  i_cfg_*   in    write enable    idx[2:0] data[3:0]
//
// One byte is taken every cycle while input is ready; a pixel of 1, 2 or 3 bytes
// gives one result (collect register, then result register).
// Reset clears the byte phase, the channel values and both valid flags, and
// loads the register defaults (3 bytes per pixel, 8-bit fields, red/green/blue).
// A stalled result holds the collect register; input stops only once both fill.
`include "packed_pixel_to_rgb888_assert.svh"

module packed_pixel_to_rgb888
    import ppr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    ppr_byte_if.sink                 i_byte,
    ppr_rgb_if.source                o_rgb
);

    t_cfg r_cfg;
    logic s_valid;
    logic s_ready;
    t_pix pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp         <= 2'd3;
            r_cfg.first_bits  <= 4'd8;
            r_cfg.second_bits <= 4'd8;
            r_cfg.third_bits  <= 4'd8;
            r_cfg.first_dest  <= CH_RED;
            r_cfg.second_dest <= CH_GREEN;
            r_cfg.third_dest  <= CH_BLUE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BPP:         r_cfg.bpp         <= i_cfg_data[1:0];
                CFG_FIRST_BITS:  r_cfg.first_bits  <= i_cfg_data;
                CFG_SECOND_BITS: r_cfg.second_bits <= i_cfg_data;
                CFG_THIRD_BITS:  r_cfg.third_bits  <= i_cfg_data;
                CFG_FIRST_DEST:  r_cfg.first_dest  <= i_cfg_data[1:0];
                CFG_SECOND_DEST: r_cfg.second_dest <= i_cfg_data[1:0];
                CFG_THIRD_DEST:  r_cfg.third_dest  <= i_cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    ppr_collect u_collect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_byte    (i_byte),
        .o_s_valid (s_valid),
        .i_s_ready (s_ready),
        .o_pix     (pix)
    );

    ppr_unpack u_unpack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_s_valid (s_valid),
        .o_s_ready (s_ready),
        .i_pix     (pix),
        .o_rgb     (o_rgb)
    );

    `PPR_ASSERT(a_stalled_out_holds, i_clk, i_rst_n,
                (o_rgb.valid && !o_rgb.ready) |=> (o_rgb.valid && $stable(o_rgb.red)))
    `PPR_ASSERT(a_full_blocks_input, i_clk, i_rst_n,
                (s_valid && o_rgb.valid && !o_rgb.ready) |-> !i_byte.ready)
    `PPR_ASSERT(a_bits_write, i_clk, i_rst_n,
                (i_cfg_we && (i_cfg_idx == CFG_FIRST_BITS)) |=>
                (r_cfg.first_bits == $past(i_cfg_data)))

endmodule
